[hw/rtl/md5_pkg.sv]
// md5_pkg: shared types, constants and per-step lookup functions for the
// md5 message digest unit. Used by md5_step and md5_message_digest_unit.
// No dependencies.
package md5_pkg;

    // input beat: one message byte plus framing flags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } md5_msg_t;

    // output beat: one chaining word of the final digest
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } md5_digest_t;

    // the four working words a..d of one compression
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } md5_words_t;

    localparam int unsigned STEP_W    = 6;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BLK_WORDS = 16;
    localparam int unsigned CNT_W     = 61;

    localparam logic [STEP_W-1:0] LAST_STEP     = 6'd63;
    localparam logic [5:0]        LAST_BYTE_POS = 6'd63;
    localparam logic [2:0]        LEN_ROW       = 3'b111;
    localparam logic [1:0]        LAST_WORD_IDX = 2'd3;
    localparam logic [7:0]        PAD_BYTE      = 8'h80;
    localparam logic [3:0]        LEN_LO_WORD   = 4'd14;
    localparam logic [3:0]        LEN_HI_WORD   = 4'd15;

    // chaining words after reset, index 0 is A
    localparam logic [3:0][WORD_W-1:0] MD5_INIT = {
        32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301
    };

    // additive constant of each step
    function automatic logic [WORD_W-1:0] md5_k(input logic [STEP_W-1:0] i);
        logic [WORD_W-1:0] k;
        k = '0;
        case (i)
            6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
            6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
            6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
            6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
            6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
            default: k = '0;
        endcase
        return k;
    endfunction

    // left rotate amount of each step
    function automatic logic [4:0] md5_rot(input logic [STEP_W-1:0] i);
        logic [4:0] s;
        s = 5'd7;
        case ({i[5:4], i[1:0]})
            4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
            4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
            4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
            4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
            default: s = 5'd7;
        endcase
        return s;
    endfunction

    // block word consumed by each step
    function automatic logic [3:0] md5_msg_sel(input logic [STEP_W-1:0] i);
        logic [3:0] g;
        logic [3:0] lo;
        lo = i[3:0];
        g  = lo;
        case (i[5:4])
            2'd0: g = lo;
            2'd1: g = 4'((lo << 2) + lo + 4'd1);
            2'd2: g = 4'((lo << 1) + lo + 4'd5);
            2'd3: g = 4'((lo << 3) - lo);
            default: g = lo;
        endcase
        return g;
    endfunction

endpackage

[hw/rtl/md5_step.sv]
// md5_step: one md5 compression step, shared across all 64 steps.
// Depends on md5_pkg for the word struct and step lookup functions.
module md5_step
    import md5_pkg::*;
(
    input  md5_words_t        cur,
    input  logic [WORD_W-1:0] msg_word,
    input  logic [STEP_W-1:0] step,
    output md5_words_t        nxt
);

    logic [WORD_W-1:0]   f;
    logic [WORD_W-1:0]   sum;
    logic [2*WORD_W-1:0] rot_wide;
    logic [WORD_W-1:0]   rot;

    // round function picked by the top two step bits
    always_comb
    begin
        case (step[5:4])
            2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
            2'd1:    f = (cur.d & cur.b) | (~cur.d & cur.c);
            2'd2:    f = cur.b ^ cur.c ^ cur.d;
            default: f = cur.c ^ (cur.b | ~cur.d);
        endcase
    end

    // add, rotate, add
    assign sum      = cur.a + f + md5_k(step) + msg_word;
    assign rot_wide = {sum, sum} << md5_rot(step);
    assign rot      = rot_wide[2*WORD_W-1:WORD_W];

    // word shuffle
    assign nxt.a = cur.d;
    assign nxt.b = cur.b + rot;
    assign nxt.c = cur.b;
    assign nxt.d = cur.c;

endmodule

[hw/rtl/md5_message_digest_unit.sv]
// md5_message_digest_unit: byte-wide md5 hash engine with padding and digest output.
// Depends on md5_pkg and md5_step.
//
// Takes one message byte per input beat, packs it little-endian into a 16-word
// block buffer and, once 64 bytes are in, runs the md5 compression on one shared
// step unit at one step per cycle in ST_COMP, then folds the words in ST_FOLD, taking
// no input beat meanwhile. A byte that neither fills a block nor ends the message
// leaves the unit ready for the next. The beat flagged end_of_message leads to a
// padding state, ST_PAD, then one compression (two when fewer than 8 bytes remain
// after the 0x80 pad, with an extra length-write state, ST_LEN), then the four
// digest words A, B, C, D leave as four output beats, the last flagged last_word.
// After the last word is taken the unit is back at its initial state.
module md5_message_digest_unit
    import md5_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_ready,
    input  md5_msg_t    msg,
    output logic        digest_valid,
    input  logic        digest_ready,
    output md5_digest_t digest
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PAD  = 6'b000010,
        ST_LEN  = 6'b000100,
        ST_COMP = 6'b001000,
        ST_FOLD = 6'b010000,
        ST_EMIT = 6'b100000
    } md5_state_t;

    md5_state_t                          state_reg, state_next;
    logic [STEP_W-1:0]                   step_reg;
    md5_words_t                          work_reg;
    md5_words_t                          step_out;
    logic [3:0][WORD_W-1:0]              chain_reg;
    logic [BLK_WORDS-1:0][WORD_W-1:0]    buf_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic                                pad_pend_reg;
    logic                                len_pend_reg;
    logic                                final_reg;
    logic [1:0]                          word_idx_reg;

    logic                                msg_fire;
    logic                                digest_fire;
    logic [5:0]                          pos;
    logic [63:0]                         bit_len;
    md5_words_t                          chain_words;

    assign msg_fire    = msg_valid & msg_ready;
    assign digest_fire = digest_valid & digest_ready;
    assign pos         = count_reg[5:0];
    assign bit_len     = {count_reg, 3'b000};

    assign chain_words.a = chain_reg[0];
    assign chain_words.b = chain_reg[1];
    assign chain_words.c = chain_reg[2];
    assign chain_words.d = chain_reg[3];

    // shared step unit
    md5_step u_step (
        .cur      (work_reg),
        .msg_word (buf_reg[md5_msg_sel(step_reg)]),
        .step     (step_reg),
        .nxt      (step_out)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_fire)
                begin
                    if (msg.byte_present && pos == LAST_BYTE_POS)
                        state_next = ST_COMP;
                    else if (msg.end_of_message)
                        state_next = ST_PAD;
                end
            end
            ST_PAD:  state_next = ST_COMP;
            ST_LEN:  state_next = ST_COMP;
            ST_COMP:
            begin
                if (step_reg == LAST_STEP)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                if (final_reg)
                    state_next = ST_EMIT;
                else if (pad_pend_reg)
                    state_next = ST_PAD;
                else if (len_pend_reg)
                    state_next = ST_LEN;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (digest_fire && word_idx_reg == LAST_WORD_IDX)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            work_reg     <= '0;
            chain_reg    <= MD5_INIT;
            buf_reg      <= '0;
            count_reg    <= '0;
            pad_pend_reg <= 1'b0;
            len_pend_reg <= 1'b0;
            final_reg    <= 1'b0;
            word_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    work_reg <= chain_words;
                    step_reg <= '0;
                    if (msg_fire)
                    begin
                        pad_pend_reg <= msg.end_of_message;
                        if (msg.byte_present)
                        begin
                            buf_reg[pos[5:2]][pos[1:0]*8 +: 8] <= msg.data_byte;
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                end
                ST_PAD:
                begin
                    work_reg     <= chain_words;
                    step_reg     <= '0;
                    pad_pend_reg <= 1'b0;
                    buf_reg[pos[5:2]][pos[1:0]*8 +: 8] <= PAD_BYTE;
                    if (pos[5:3] == LEN_ROW)
                        len_pend_reg <= 1'b1;
                    else
                    begin
                        buf_reg[LEN_LO_WORD] <= bit_len[31:0];
                        buf_reg[LEN_HI_WORD] <= bit_len[63:32];
                        final_reg            <= 1'b1;
                    end
                end
                ST_LEN:
                begin
                    work_reg             <= chain_words;
                    step_reg             <= '0;
                    len_pend_reg         <= 1'b0;
                    buf_reg[LEN_LO_WORD] <= bit_len[31:0];
                    buf_reg[LEN_HI_WORD] <= bit_len[63:32];
                    final_reg            <= 1'b1;
                end
                ST_COMP:
                begin
                    work_reg <= step_out;
                    step_reg <= step_reg + 1'b1;
                end
                ST_FOLD:
                begin
                    chain_reg[0] <= chain_reg[0] + work_reg.a;
                    chain_reg[1] <= chain_reg[1] + work_reg.b;
                    chain_reg[2] <= chain_reg[2] + work_reg.c;
                    chain_reg[3] <= chain_reg[3] + work_reg.d;
                    buf_reg      <= '0;
                end
                ST_EMIT:
                begin
                    if (digest_fire)
                    begin
                        word_idx_reg <= word_idx_reg + 1'b1;
                        if (word_idx_reg == LAST_WORD_IDX)
                        begin
                            chain_reg <= MD5_INIT;
                            count_reg <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // handshake and output beat
    assign msg_ready           = (state_reg == ST_IDLE);
    assign digest_valid        = (state_reg == ST_EMIT);
    assign digest.digest_word  = chain_reg[word_idx_reg];
    assign digest.word_index   = word_idx_reg;
    assign digest.last_word    = (word_idx_reg == LAST_WORD_IDX);

`ifndef SYNTHESIS
    // step counter only moves during compression
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COMP) |-> (step_reg == '0))
        else $error("step counter nonzero outside compression");

    // compression runs all 64 steps before folding
    a_comp_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COMP && step_reg != LAST_STEP) |=> (state_reg == ST_COMP))
        else $error("compression left early");

    // final block is only scheduled after padding and length are done
    a_final_clean: assert property (@(posedge clk) disable iff (!rst_n)
        final_reg |-> (!len_pend_reg && !pad_pend_reg))
        else $error("final flag with padding still pending");

    // last digest beat returns the unit to its initial state
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (digest_fire && word_idx_reg == LAST_WORD_IDX) |=>
        (chain_reg == MD5_INIT && count_reg == '0 && state_reg == ST_IDLE))
        else $error("unit not reinitialized after digest");
`endif

endmodule
